// File: design/spot_pkg.sv
// ----------------------------------------------------------------------------
// spot_pkg: shared types and microprogram for the scaled periodic timer
// Holds command codes, register indexes, control word layout and the
// control store that sequences the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package spot_pkg;

	localparam int PERIOD_W = 32;
	localparam int GAIN_W   = 16;
	localparam int DELTA_W  = 32;
	localparam int MODE_W   = 3;
	localparam int EXP_W    = 8;
	localparam int STEP_W   = 4;

	typedef logic [STEP_W-1:0] step_t;

	// command codes carried with each input word
	typedef enum logic [MODE_W-1:0] {
		MODE_TICK    = 3'd0,
		MODE_PLAY    = 3'd1,
		MODE_PAUSE   = 3'd2,
		MODE_STOP    = 3'd3,
		MODE_RESTART = 3'd4
	} mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_PERIOD   = 2'd0,
		CFG_GAIN     = 2'd1,
		CFG_ONE_SHOT = 2'd2,
		CFG_FROZEN   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_length;
		logic [GAIN_W-1:0]   time_gain;
		logic                one_shot;
		logic                frozen;
	} cfg_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_TAKE,
		OP_DECODE,
		OP_ADD,
		OP_DSTEP,
		OP_FINP,
		OP_LOADE,
		OP_FINE,
		OP_EMIT
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_NO_ADD,
		C_DIV_BUSY,
		C_NO_MOD,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  wrap;
	} ctl_t;

	// status from datapath to sequencer
	typedef struct packed {
		logic no_add;
		logic div_busy;
		logic no_mod;
	} flags_t;

	typedef struct packed {
		logic [EXP_W-1:0]    expiries;
		logic                done_res;
		logic                running;
		logic [PERIOD_W-1:0] elapsed;
		logic [PERIOD_W-1:0] remaining;
	} res_t;

	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_DECODE = 4'd1;
	localparam step_t ST_ADD    = 4'd2;
	localparam step_t ST_DIVP   = 4'd3;
	localparam step_t ST_ENDP   = 4'd4;
	localparam step_t ST_REM    = 4'd5;
	localparam step_t ST_DIVE   = 4'd6;
	localparam step_t ST_ENDE   = 4'd7;
	localparam step_t ST_OUT    = 4'd8;

	// control store: jump to target when the condition holds, else fall through, or return to idle on a wrap step
	function automatic ctl_t ucode(input step_t s);
		ctl_t c;
		c = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE, wrap: 1'b0};
		case (s)
			ST_IDLE:   c = '{op: OP_TAKE,   cond: C_NO_ITEM,  target: ST_IDLE, wrap: 1'b0};
			ST_DECODE: c = '{op: OP_DECODE, cond: C_NO_ADD,   target: ST_REM,  wrap: 1'b0};
			ST_ADD:    c = '{op: OP_ADD,    cond: C_NEVER,    target: ST_IDLE, wrap: 1'b0};
			ST_DIVP:   c = '{op: OP_DSTEP,  cond: C_DIV_BUSY, target: ST_DIVP, wrap: 1'b0};
			ST_ENDP:   c = '{op: OP_FINP,   cond: C_NEVER,    target: ST_IDLE, wrap: 1'b0};
			ST_REM:    c = '{op: OP_LOADE,  cond: C_NO_MOD,   target: ST_OUT,  wrap: 1'b0};
			ST_DIVE:   c = '{op: OP_DSTEP,  cond: C_DIV_BUSY, target: ST_DIVE, wrap: 1'b0};
			ST_ENDE:   c = '{op: OP_FINE,   cond: C_NEVER,    target: ST_IDLE, wrap: 1'b0};
			ST_OUT:    c = '{op: OP_EMIT,   cond: C_OUT_FULL, target: ST_OUT,  wrap: 1'b1};
			default:   c = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_IDLE, wrap: 1'b0};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: design/spot_seq.sv
// ----------------------------------------------------------------------------
// spot_seq: microprogram sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module spot_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire spot_pkg::flags_t flags,
	input  wire logic            item_valid,
	input  wire logic            out_full,
	output spot_pkg::op_t        op
);
	import spot_pkg::*;

	step_t step_q;
	ctl_t  ctl;
	logic  taken;
	step_t step_d;

	always_comb begin
		ctl = ucode(step_q);
		case (ctl.cond)
			C_NEVER:    taken = 1'b0;
			C_ALWAYS:   taken = 1'b1;
			C_NO_ITEM:  taken = !item_valid;
			C_NO_ADD:   taken = flags.no_add;
			C_DIV_BUSY: taken = flags.div_busy;
			C_NO_MOD:   taken = flags.no_mod;
			C_OUT_FULL: taken = out_full;
			default:    taken = 1'b1;
		endcase
		if (taken) begin
			step_d = ctl.target;
		end else if (ctl.wrap) begin
			step_d = ST_IDLE;
		end else begin
			step_d = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	assign op = ctl.op;

	// the program never leaves its nine steps
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ST_OUT)
		else $error("sequencer step out of program");

endmodule

`default_nettype wire

// File: design/spot_dpath.sv
// ----------------------------------------------------------------------------
// spot_dpath: timer datapath
// Gain multiplier, saturating adders, timer state and a restoring divider
// shared by expiry counting and the remaining-time modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module spot_dpath #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire spot_pkg::op_t                 op,
	input  wire spot_pkg::cfg_t                cfg,
	input  wire logic                          take,
	input  wire logic [spot_pkg::MODE_W-1:0]   mode,
	input  wire logic [spot_pkg::DELTA_W-1:0]  delta,
	output spot_pkg::flags_t                   flags,
	output spot_pkg::res_t                     res
);
	import spot_pkg::*;

	localparam int TW    = TIME_WIDTH;
	localparam int CNT_W = $clog2(TW);
	localparam int PROD_W = DELTA_W + GAIN_W;
	localparam int SH_W  = PROD_W - 8;

	logic [MODE_W-1:0]  mode_q;
	logic [DELTA_W-1:0] delta_q;
	logic [TW-1:0]      elapsed_q;
	logic [TW-1:0]      phase_q;
	logic               playing_q;
	logic               finished_q;
	logic               first_q;
	logic [TW-1:0]      scaled_q;
	logic [TW-1:0]      dq_q;
	logic [TW-1:0]      r_q;
	logic [EXP_W-1:0]   qbits_q;
	logic               qsat_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [EXP_W-1:0]   exp_q;
	logic [TW-1:0]      rem_q;

	logic [TW-1:0]      p;
	logic               gated;
	logic [PROD_W-1:0]  prod;
	logic [SH_W-1:0]    prod_sh;
	logic [TW-1:0]      scaled;
	logic [TW:0]        sum_e;
	logic [TW:0]        sum_p;
	logic [TW-1:0]      elapsed_sat;
	logic [TW-1:0]      phase_sat;
	logic [TW:0]        trial;
	logic               ge;
	logic [TW:0]        diff;
	logic               any_exp;

	always_comb begin
		p       = TW'(cfg.period_length);
		gated   = cfg.frozen || (p == '0) || !playing_q || finished_q;
		prod    = PROD_W'(delta_q) * PROD_W'(cfg.time_gain);
		prod_sh = prod[PROD_W-1:8];
		// product above the time range clamps to all ones
		scaled  = ((prod_sh >> TW) != '0) ? '1 : TW'(prod_sh);
		sum_e   = {1'b0, elapsed_q} + {1'b0, scaled_q};
		sum_p   = {1'b0, phase_q} + {1'b0, scaled_q};
		elapsed_sat = sum_e[TW] ? '1 : sum_e[TW-1:0];
		phase_sat   = sum_p[TW] ? '1 : sum_p[TW-1:0];
		// one restoring division step
		trial   = {r_q, dq_q[TW-1]};
		diff    = trial - {1'b0, p};
		ge      = !diff[TW] || trial[TW];
		any_exp = qsat_q || (qbits_q != '0);
		flags.no_add   = (mode_q != MODE_TICK) || gated || first_q;
		flags.div_busy = (cnt_q != '0);
		flags.no_mod   = (p == '0) || (elapsed_q <= p);
	end

	// timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q  <= '0;
			phase_q    <= '0;
			playing_q  <= 1'b0;
			finished_q <= 1'b0;
			first_q    <= 1'b1;
		end else begin
			case (op)
				OP_DECODE: begin
					case (mode_q)
						MODE_TICK: begin
							if (!gated && first_q) begin
								elapsed_q <= '0;
								phase_q   <= '0;
								first_q   <= 1'b0;
							end
						end
						MODE_PLAY: begin
							playing_q <= 1'b1;
							first_q   <= 1'b1;
						end
						MODE_PAUSE: begin
							playing_q <= 1'b0;
						end
						MODE_STOP: begin
							elapsed_q  <= '0;
							finished_q <= 1'b0;
							first_q    <= 1'b1;
							playing_q  <= 1'b0;
						end
						MODE_RESTART: begin
							elapsed_q  <= '0;
							finished_q <= 1'b0;
							first_q    <= 1'b1;
							playing_q  <= 1'b1;
						end
						default: begin
						end
					endcase
				end
				OP_ADD: begin
					elapsed_q <= elapsed_sat;
				end
				OP_FINP: begin
					phase_q <= r_q;
					if (any_exp && cfg.one_shot) begin
						finished_q <= 1'b1;
						first_q    <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// input capture, product and divider
	always_ff @(posedge clk) begin
		if (take) begin
			mode_q  <= mode;
			delta_q <= delta;
		end
		case (op)
			OP_DECODE: begin
				scaled_q <= scaled;
				exp_q    <= '0;
			end
			OP_ADD: begin
				dq_q    <= phase_sat;
				r_q     <= '0;
				qbits_q <= '0;
				qsat_q  <= 1'b0;
				cnt_q   <= CNT_W'(TW - 1);
			end
			OP_DSTEP: begin
				r_q     <= ge ? diff[TW-1:0] : trial[TW-1:0];
				dq_q    <= {dq_q[TW-2:0], 1'b0};
				qbits_q <= {qbits_q[EXP_W-2:0], ge};
				qsat_q  <= qsat_q || qbits_q[EXP_W-1];
				cnt_q   <= cnt_q - 1'b1;
			end
			OP_FINP: begin
				exp_q <= qsat_q ? '1 : qbits_q;
			end
			OP_LOADE: begin
				dq_q    <= elapsed_q;
				r_q     <= '0;
				qbits_q <= '0;
				qsat_q  <= 1'b0;
				cnt_q   <= CNT_W'(TW - 1);
				rem_q   <= (p == '0) ? '0 : p - elapsed_q;
			end
			OP_FINE: begin
				rem_q <= p - r_q;
			end
			default: begin
			end
		endcase
	end

	assign res.expiries  = exp_q;
	assign res.done_res  = finished_q;
	assign res.running   = playing_q;
	assign res.elapsed   = PERIOD_W'(elapsed_q);
	assign res.remaining = PERIOD_W'(rem_q);

	// a finished timer always restarts from a clearing tick
	a_fin_first: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> first_q)
		else $error("finished without first tick pending");

	// partial remainder stays below the period while dividing
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_DSTEP) |-> (r_q < p))
		else $error("divider remainder not below period");

endmodule

`default_nettype wire

// File: design/scaled_periodic_oneshot_timer.sv
// ----------------------------------------------------------------------------
// scaled_periodic_oneshot_timer: gain-scaled periodic / one-shot timer
// Microcoded sequencer over a timer datapath; one status word per command.
// ----------------------------------------------------------------------------
// channel   dir  handshake         payload
// s_*       in   s_tvalid/s_tready s_tuser mode, s_tdata delta
// m_*       out  m_tvalid/m_tready m_tdata expiries..remaining
// cfg_*     in   cfg_we            cfg_index, cfg_data
//
// a word steps through take, decode, remainder setup and output when nothing is divided;
// an advancing tick adds an add step and phase / period on the bit-serial restoring
// divider with its finish step, and an elapsed time above the period adds elapsed mod
// period on the same divider with its finish step; input is taken only at the idle step
// a finished word waits in the output register while the next word is accepted and
// worked on; reset clears the timer state and the configuration registers to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_periodic_oneshot_timer #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // delta[31:0]
	input  wire logic [2:0]  s_tuser,   // mode[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // expiries[7:0], done_res[8], running[9],
	                                    // elapsed[41:10], remaining[73:42], zero pad
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import spot_pkg::*;

	cfg_t   cfg_q;
	op_t    op;
	flags_t flags;
	res_t   res;
	logic   out_full;
	logic   take;
	logic   emit;
	logic   m_tvalid_q;
	logic [79:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_length <= '0;
			cfg_q.time_gain     <= GAIN_W'(256);
			cfg_q.one_shot      <= 1'b0;
			cfg_q.frozen        <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PERIOD:   cfg_q.period_length <= cfg_data;
				CFG_GAIN:     cfg_q.time_gain     <= cfg_data[GAIN_W-1:0];
				CFG_ONE_SHOT: cfg_q.one_shot      <= cfg_data[0];
				CFG_FROZEN:   cfg_q.frozen        <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign s_tready = (op == OP_TAKE);
	assign take     = s_tvalid && s_tready;
	assign out_full = m_tvalid_q && !m_tready;
	assign emit     = (op == OP_EMIT) && !out_full;

	spot_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.flags      (flags),
		.item_valid (s_tvalid),
		.out_full   (out_full),
		.op         (op)
	);

	spot_dpath #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.cfg    (cfg_q),
		.take   (take),
		.mode   (s_tuser),
		.delta  (s_tdata),
		.flags  (flags),
		.res    (res)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {6'd0, res.remaining, res.elapsed, res.running,
				res.done_res, res.expiries};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_no_take_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(take && emit))
		else $error("input taken while a word is emitted");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !s_tready)
		else $error("ready again right after accepting a word");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_tvalid)
		else $error("emitted word not presented");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: scaled periodic / one-shot timer
// Streams timer commands into the block and checks every status word against
// a local timer model. The run has a directed part followed by random phases.
// Every phase writes the timer registers, then runs play or restart followed
// by tick bursts sized against the period, and some stray commands. Random
// idle bursts on both sides, switched off in the last phase.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import spot_pkg::*;

	localparam int          LIMIT_CYCLES  = 1_000_000;
	localparam int          DRAIN_CYCLES  = 150;
	localparam int          RAND_PHASES   = 10;
	localparam int          PHASE_ITEMS   = 150;
	localparam int          MAX_REPORTS   = 10;
	localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;
	localparam logic [31:0] ONE_SECOND    = 32'h0001_0000;
	localparam logic [15:0] GAIN_UNITY    = 16'd256;
	localparam logic [2:0]  MODE_UNDEF_LO = 3'd5;
	localparam logic [2:0]  MODE_UNDEF_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] delta;
	} timer_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	scaled_periodic_oneshot_timer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // delta[31:0]
		.s_tuser   (s_tuser),   // mode[2:0]
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // expiries[7:0], done_res[8], running[9],
		                        // elapsed[41:10], remaining[73:42], zero pad
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// timer model: registers and state
	logic [31:0] cf_period   = '0;
	logic [15:0] cf_gain     = GAIN_UNITY;
	logic        cf_one_shot = 1'b0;
	logic        cf_frozen   = 1'b0;
	logic [31:0] tm_elapsed  = '0;
	logic [31:0] tm_phase    = '0;
	logic        tm_playing  = 1'b0;
	logic        tm_finished = 1'b0;
	logic        tm_first    = 1'b1;

	timer_cmd_t cmd_queue[$];
	res_t       status_queue[$];

	bit calm = 1'b0;
	int errors = 0;
	int reports = 0;
	int cycles = 0;
	int results_seen = 0;
	int advancing_ticks = 0;
	int expiries_total = 0;
	int finish_events = 0;
	int settings_used = 0;
	int gap_left = 0;
	int stall_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[32] ? TIME_MAX : sum[31:0];
	endfunction

	// advance the timer model by one command, return the status word it yields
	function automatic res_t step_timer(input logic [2:0] mode, input logic [31:0] delta);
		res_t        r;
		logic [63:0] scaled;
		logic [31:0] n;
		r.expiries = '0;
		case (mode)
			MODE_TICK: begin
				if (!cf_frozen && cf_period != 0 && tm_playing && !tm_finished) begin
					if (tm_first) begin
						// first tick after a start, stop or one-shot finish only clears the time base
						tm_elapsed = '0;
						tm_phase   = '0;
						tm_first   = 1'b0;
					end else begin
						scaled = (64'(delta) * 64'(cf_gain)) >> 8;
						if (scaled > 64'(TIME_MAX))
							scaled = 64'(TIME_MAX);
						tm_elapsed = sat_add(tm_elapsed, scaled[31:0]);
						tm_phase   = sat_add(tm_phase, scaled[31:0]);
						n          = tm_phase / cf_period;
						tm_phase   = tm_phase % cf_period;
						r.expiries = (n > 32'd255) ? 8'd255 : n[7:0];
						advancing_ticks++;
						expiries_total += r.expiries;
						if (n != 0 && cf_one_shot) begin
							tm_finished = 1'b1;
							tm_first    = 1'b1;
							finish_events++;
						end
					end
				end
			end
			MODE_PLAY: begin
				tm_playing = 1'b1;
				tm_first   = 1'b1;
			end
			MODE_PAUSE: begin
				tm_playing = 1'b0;
			end
			MODE_STOP: begin
				tm_elapsed  = '0;
				tm_finished = 1'b0;
				tm_first    = 1'b1;
				tm_playing  = 1'b0;
			end
			MODE_RESTART: begin
				tm_elapsed  = '0;
				tm_finished = 1'b0;
				tm_first    = 1'b1;
				tm_playing  = 1'b1;
			end
			default: begin
			end
		endcase
		r.done_res = tm_finished;
		r.running  = tm_playing;
		r.elapsed  = tm_elapsed;
		if (cf_period == 0)
			r.remaining = '0;
		else if (tm_elapsed > cf_period)
			r.remaining = cf_period - (tm_elapsed % cf_period);
		else
			r.remaining = cf_period - tm_elapsed;
		return r;
	endfunction

	// driver: offer queued commands, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				status_queue.push_back(step_timer(s_tuser, s_tdata));
				void'(cmd_queue.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				if (!calm && $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(1, 6) - 1;
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tuser  <= cmd_queue[0].mode;
					s_tdata  <= cmd_queue[0].delta;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: random back-pressure and status word check
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.expiries  = m_tdata[7:0];
				got.done_res  = m_tdata[8];
				got.running   = m_tdata[9];
				got.elapsed   = m_tdata[41:10];
				got.remaining = m_tdata[73:42];
				results_seen++;
				if (status_queue.size() == 0) begin
					errors++;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("unexpected status word %h", m_tdata);
					end
				end else begin
					want = status_queue.pop_front();
					if (got.expiries != want.expiries || got.done_res != want.done_res ||
					    got.running != want.running || got.elapsed != want.elapsed ||
					    got.remaining != want.remaining) begin
						errors++;
						if (reports < MAX_REPORTS) begin
							reports++;
							$display("word %0d: expected exp=%0d done=%0d run=%0d el=%h rem=%h",
							         results_seen, want.expiries, want.done_res, want.running,
							         want.elapsed, want.remaining);
							$display("word %0d: got      exp=%0d done=%0d run=%0d el=%h rem=%h",
							         results_seen, got.expiries, got.done_res, got.running,
							         got.elapsed, got.remaining);
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_PERIOD:   cf_period   = val;
			CFG_GAIN:     cf_gain     = val[15:0];
			CFG_ONE_SHOT: cf_one_shot = val[0];
			CFG_FROZEN:   cf_frozen   = val[0];
			default: begin
			end
		endcase
	endtask

	task automatic set_regs(input logic [31:0] period, input logic [15:0] gain,
	                        input logic one_shot, input logic frozen);
		write_reg(CFG_PERIOD, period);
		write_reg(CFG_GAIN, {16'd0, gain});
		write_reg(CFG_ONE_SHOT, {31'd0, one_shot});
		write_reg(CFG_FROZEN, {31'd0, frozen});
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic push_cmd(input logic [2:0] mode, input logic [31:0] delta);
		timer_cmd_t c;
		c.mode  = mode;
		c.delta = delta;
		cmd_queue.push_back(c);
	endtask

	task automatic wait_idle;
		while (cmd_queue.size() != 0 || status_queue.size() != 0)
			@(posedge clk);
	endtask

	// tick step, mostly sized against the current period and gain
	function automatic logic [31:0] pick_delta;
		logic [63:0] target;
		logic [63:0] d;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return TIME_MAX;
			2: return $urandom();
			3: return $urandom_range(0, 255);
			default: begin
				target = (64'(cf_period) * 64'($urandom_range(0, 12))) >> 2;
				if (cf_gain == 0)
					return $urandom();
				d = (target << 8) / 64'(cf_gain) + 64'($urandom_range(0, 1));
				return (d > 64'(TIME_MAX)) ? TIME_MAX : d[31:0];
			end
		endcase
	endfunction

	task automatic random_regs;
		logic [31:0] period;
		logic [15:0] gain;
		case ($urandom_range(0, 9))
			0:       period = '0;
			1:       period = TIME_MAX;
			2:       period = 32'd1;
			3:       period = $urandom_range(1, 1000);
			4, 5, 6: period = {16'($urandom_range(1, 8)), 16'($urandom_range(0, 65535))};
			default: period = $urandom();
		endcase
		case ($urandom_range(0, 9))
			6:       gain = '0;
			7:       gain = 16'hFFFF;
			8, 9:    gain = 16'($urandom_range(0, 65535));
			default: gain = GAIN_UNITY;
		endcase
		set_regs(period, gain, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
	endtask

	task automatic random_items(input int count);
		int added;
		int k;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 9) < 8) begin
				// start, clearing tick, then a burst of advancing ticks
				push_cmd($urandom_range(0, 1) ? MODE_RESTART : MODE_PLAY, $urandom());
				push_cmd(MODE_TICK, $urandom());
				added += 2;
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++) begin
					push_cmd(MODE_TICK, pick_delta());
					added++;
					if ($urandom_range(0, 15) == 0) begin
						push_cmd(MODE_PAUSE, $urandom());
						push_cmd(MODE_TICK, pick_delta());
						push_cmd(MODE_PLAY, $urandom());
						push_cmd(MODE_TICK, pick_delta());
						added += 4;
					end
				end
				if ($urandom_range(0, 5) == 0) begin
					push_cmd(MODE_STOP, $urandom());
					added++;
				end
			end else begin
				k = $urandom_range(1, 4);
				for (int i = 0; i < k; i++) begin
					push_cmd(3'($urandom_range(0, 7)), $urandom());
					added++;
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at their reset values: zero period, ticks have no effect
		settings_used++;
		push_cmd(MODE_TICK, ONE_SECOND);
		push_cmd(MODE_RESTART, '0);
		push_cmd(MODE_TICK, ONE_SECOND);
		wait_idle();

		// one second period, unity gain, repeating
		set_regs(ONE_SECOND, GAIN_UNITY, 1'b0, 1'b0);
		push_cmd(MODE_PLAY, '0);
		push_cmd(MODE_TICK, TIME_MAX);
		push_cmd(MODE_TICK, ONE_SECOND);
		push_cmd(MODE_TICK, 32'h0000_8000);
		push_cmd(MODE_TICK, 32'h0003_4000);
		push_cmd(MODE_TICK, TIME_MAX);
		push_cmd(MODE_PAUSE, '0);
		push_cmd(MODE_TICK, ONE_SECOND);
		push_cmd(MODE_PLAY, TIME_MAX);
		push_cmd(MODE_TICK, '0);
		push_cmd(MODE_TICK, '0);
		for (int m = MODE_UNDEF_LO; m <= MODE_UNDEF_HI; m++)
			push_cmd(m[2:0], TIME_MAX);
		push_cmd(MODE_STOP, '0);
		push_cmd(MODE_RESTART, '0);
		wait_idle();

		// largest period and gain, one-shot: saturation then finish
		set_regs(TIME_MAX, 16'hFFFF, 1'b1, 1'b0);
		push_cmd(MODE_RESTART, '0);
		push_cmd(MODE_TICK, '0);
		push_cmd(MODE_TICK, 32'h0000_0100);
		push_cmd(MODE_TICK, TIME_MAX);
		push_cmd(MODE_TICK, ONE_SECOND);
		push_cmd(MODE_PLAY, '0);
		push_cmd(MODE_TICK, ONE_SECOND);
		wait_idle();

		// frozen with zero gain, shortest period
		set_regs(32'd1, 16'd0, 1'b0, 1'b1);
		push_cmd(MODE_RESTART, '0);
		push_cmd(MODE_TICK, TIME_MAX);
		push_cmd(MODE_TICK, TIME_MAX);
		wait_idle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == RAND_PHASES - 1)
				calm = 1'b1;
			random_regs();
			random_items(PHASE_ITEMS);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		errors += status_queue.size();

		$display("checked %0d status words over %0d register settings", results_seen,
		         settings_used);
		$display("%0d ticks advanced the timer, %0d periods expired, %0d one-shot finishes",
		         advancing_ticks, expiries_total, finish_events);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
design/spot_pkg.sv
design/spot_seq.sv
design/spot_dpath.sv
design/scaled_periodic_oneshot_timer.sv
sim/testbench.sv
